/* design/ipv4_dotted_quad_parser_defines.svh */
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser assertion macros
// Shared assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH

// General clocked property check.
`define IPV4DQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The condition must never be true at a clock edge.
`define IPV4DQ_NEVER(label, cond, msg) \
    `IPV4DQ_ASSERT(label, !(cond), msg)

`endif

/* design/ipv4dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser package
// Character codes, limits and the parse state and result types.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [9:0] OCTET_MAX   = 10'd255;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;
    localparam logic [2:0] DOTS_SAT    = 3'd4;
    localparam logic [2:0] DIGITS_MAX  = 3'd3;

    typedef struct packed {
        logic [9:0]      seg_value;
        logic [2:0]      seg_digits;
        logic            seg_lead_zero;
        logic [2:0]      dots_seen;
        logic            reject;
        logic            at_first_char;
        logic [2:0][7:0] done_octets;
    } t_parse_state;

    typedef struct packed {
        logic       addr_valid;
        logic [7:0] octet_first;
        logic [7:0] octet_second;
        logic [7:0] octet_third;
        logic [7:0] octet_fourth;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        seg_value:     10'd0,
        seg_digits:    3'd0,
        seg_lead_zero: 1'b0,
        dots_seen:     3'd0,
        reject:        1'b0,
        at_first_char: 1'b1,
        done_octets:   '0
    };

endpackage

/* design/ipv4dq_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser step
// Next parse state and terminator result for one character word.
// ----------------------------------------------------------------------------
module ipv4dq_step
    import ipv4dq_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char_code,
    input  logic         i_end_of_string,
    output t_parse_state o_state,
    output t_result      o_result
);

    logic       is_digit;
    logic       is_dot;
    logic       seg_ok;
    logic [9:0] digit_val;
    logic [9:0] value_x10;
    logic       ok;

    assign is_digit  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign is_dot    = (i_char_code == CH_DOT);
    assign digit_val = {2'b00, i_char_code - CH_ZERO};
    assign value_x10 = {i_state.seg_value[6:0], 3'b000} + {i_state.seg_value[8:0], 1'b0};

    assign seg_ok = (i_state.seg_digits != 3'd0)
                 && !(i_state.seg_lead_zero && (i_state.seg_digits > 3'd1))
                 && (i_state.seg_value <= OCTET_MAX);

    assign ok = !i_state.at_first_char && !i_state.reject
             && (i_state.dots_seen == DOTS_NEEDED) && seg_ok;

    always_comb begin
        o_result.addr_valid   = ok;
        o_result.octet_first  = ok ? i_state.done_octets[0] : 8'd0;
        o_result.octet_second = ok ? i_state.done_octets[1] : 8'd0;
        o_result.octet_third  = ok ? i_state.done_octets[2] : 8'd0;
        o_result.octet_fourth = ok ? i_state.seg_value[7:0] : 8'd0;
    end

    always_comb begin
        o_state = i_state;
        if (i_end_of_string) begin
            o_state = PARSE_RESET;
        end else begin
            if (i_state.at_first_char && (i_char_code == CH_ZERO)) begin
                o_state.reject = 1'b1;
            end
            o_state.at_first_char = 1'b0;
            if (is_digit) begin
                if ((i_state.seg_digits == 3'd0) && (i_char_code == CH_ZERO)) begin
                    o_state.seg_lead_zero = 1'b1;
                end
                if (i_state.seg_digits >= DIGITS_MAX) begin
                    o_state.reject = 1'b1;
                end else begin
                    o_state.seg_value  = value_x10 + digit_val;
                    o_state.seg_digits = i_state.seg_digits + 3'd1;
                end
            end else if (is_dot) begin
                if (!seg_ok) begin
                    o_state.reject = 1'b1;
                end
                if (i_state.dots_seen < DOTS_NEEDED) begin
                    o_state.done_octets[i_state.dots_seen[1:0]] = i_state.seg_value[7:0];
                end
                // The count saturates; the fourth dot already rejects the string.
                if (i_state.dots_seen < DOTS_SAT) begin
                    o_state.dots_seen = i_state.dots_seen + 3'd1;
                end
                if (i_state.dots_seen >= DOTS_NEEDED) begin
                    o_state.reject = 1'b1;
                end
                o_state.seg_value     = 10'd0;
                o_state.seg_digits    = 3'd0;
                o_state.seg_lead_zero = 1'b0;
            end else begin
                o_state.reject = 1'b1;
            end
        end
    end

endmodule

/* design/ipv4_dotted_quad_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser
// Parses an address string, one character per word, into four octets.
//
// The input channel (i_in_valid / o_in_ready) carries one ASCII character per
// word, followed by a word with i_end_of_string set that ends the string.
// The output channel (o_out_valid / i_out_ready) gives one word per
// terminator: o_addr_valid and the four octets, all zero when invalid.
// Character words produce no output word.
// Every word passes through an input register and one level of parse logic;
// a terminator's result goes from the input register into the output register
// once the output register is free. One word is accepted every cycle unless a
// terminator waits in the input register for the output register.
// When the receiver stalls, the result waits in the output register and
// characters of the next string keep flowing; only a second terminator waits
// in the input register until the output register is taken.
// Reset empties both registers and returns the parser to the start of a
// string; the parser also returns there after every terminator.
// ----------------------------------------------------------------------------
`include "ipv4_dotted_quad_parser_defines.svh"

module ipv4_dotted_quad_parser
    import ipv4dq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_addr_valid,
    output logic [7:0] o_octet_first,
    output logic [7:0] o_octet_second,
    output logic [7:0] o_octet_third,
    output logic [7:0] o_octet_fourth
);

    logic         r_in_valid;
    logic [7:0]   r_char;
    logic         r_eos;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_result      r_result;
    t_result      n_result;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_eos || out_free);
    assign o_in_ready = !r_in_valid || advance;

    ipv4dq_step u_step (
        .i_state         (r_state),
        .i_char_code     (r_char),
        .i_end_of_string (r_eos),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_eos  <= i_end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_eos) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_eos) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_addr_valid   = r_result.addr_valid;
    assign o_octet_first  = r_result.octet_first;
    assign o_octet_second = r_result.octet_second;
    assign o_octet_third  = r_result.octet_third;
    assign o_octet_fourth = r_result.octet_fourth;

    `IPV4DQ_ASSERT(a_invalid_zero,
        (o_out_valid && !o_addr_valid) |-> ((o_octet_first == 8'd0)
            && (o_octet_second == 8'd0) && (o_octet_third == 8'd0)
            && (o_octet_fourth == 8'd0)),
        "rejected address carries nonzero octets")
    `IPV4DQ_ASSERT(a_restart,
        (advance && r_eos) |=> (r_state.at_first_char
            && (r_state.dots_seen == 3'd0) && !r_state.reject),
        "parser did not restart after terminator")
    `IPV4DQ_NEVER(a_dots_sat, r_state.dots_seen > DOTS_SAT, "dot count beyond saturation")
    `IPV4DQ_NEVER(a_digits_max, r_state.seg_digits > DIGITS_MAX,
        "segment digit count beyond limit")
    `IPV4DQ_NEVER(a_no_overwrite, r_out_valid && !i_out_ready && advance && r_eos,
        "result overwritten while stalled")

endmodule
